>>> rtl/irpc_pkg.sv
// Shared types and constants for the IR pulse presence classifier.
package irpc_pkg;

    localparam int DATA_W    = 16;
    localparam int MCAND_W   = 18;
    localparam int PROD_HI_W = 19;
    localparam int ADDR_W    = 5;
    localparam int PDATA_W   = 32;

    localparam logic [MCAND_W-1:0] HYSTERESIS = 18'd20;

    localparam logic [2:0] REG_LOWPASS_COEF    = 3'd0;
    localparam logic [2:0] REG_HIGHPASS_COEF   = 3'd1;
    localparam logic [2:0] REG_WARMUP_TICKS    = 3'd2;
    localparam logic [2:0] REG_PULSE_TIMEOUT   = 3'd3;
    localparam logic [2:0] REG_SHORT_THRESHOLD = 3'd4;
    localparam logic [2:0] REG_LONG_THRESHOLD  = 3'd5;

    localparam logic [DATA_W-1:0] RST_LOWPASS_COEF    = 16'd32768;
    localparam logic [DATA_W-1:0] RST_HIGHPASS_COEF   = 16'd25298;
    localparam logic [DATA_W-1:0] RST_WARMUP_TICKS    = 16'd1000;
    localparam logic [DATA_W-1:0] RST_PULSE_TIMEOUT   = 16'd100;
    localparam logic [DATA_W-1:0] RST_SHORT_THRESHOLD = 16'd5;
    localparam logic [DATA_W-1:0] RST_LONG_THRESHOLD  = 16'd20;

    localparam logic [1:0] CLASS_HIDDEN = 2'd0;
    localparam logic [1:0] CLASS_SHORT  = 2'd1;
    localparam logic [1:0] CLASS_LONG   = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_HP   = 5'b00010,
        ST_LP   = 5'b00100,
        ST_DET  = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    // Request to the serial multiplier.
    typedef struct packed {
        logic                      start;
        logic signed [MCAND_W-1:0] mcand;
        logic [DATA_W-1:0]         mplier;
    } mul_req_t;

endpackage

>>> rtl/irpc_smul.sv
// Bit-serial signed-by-unsigned multiplier, returns product >>> 16.
module irpc_smul
    import irpc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  mul_req_t                    req,
    output logic                        done,
    output logic signed [PROD_HI_W-1:0] prod_hi
);

    logic signed [PROD_HI_W-1:0] hi_reg, hi_next;
    logic [DATA_W-1:0]           lo_reg, lo_next;
    logic signed [MCAND_W-1:0]   mcand_reg;
    logic [3:0]                  cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic signed [PROD_HI_W-1:0] sum;

    // One multiplier bit per cycle; partial sum shifts right into lo.
    always_comb
    begin
        sum = hi_reg;
        if (lo_reg[0])
        begin
            sum = hi_reg + PROD_HI_W'(mcand_reg);
        end
        hi_next = sum >>> 1;
        lo_next = {sum[0], lo_reg[DATA_W-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            hi_reg    <= '0;
            lo_reg    <= req.mplier;
            mcand_reg <= req.mcand;
        end
        else if (busy_reg)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign done    = done_reg;
    assign prod_hi = hi_reg;

endmodule

>>> rtl/ir_pulse_presence_classifier.sv
// IR pulse presence classifier: takes one 16-bit ADC sample per beat and returns one
// result beat (class, pulse flag, pulse count). During warm-up a sample only bumps the
// warm-up counter: acceptance moves the sequencer to the finish state, whose exit loads
// the result register and returns to idle, where the next sample can be taken. After
// warm-up the sample runs a high-pass then a low-pass filter, each on one shared
// bit-serial multiplier, then a detect/count step and the finish state, whose exit
// loads the result register and returns to idle.
// One sample is in work at a time; the input stalls until the previous sample has
// reached the output register, which can still hold a result waiting to be taken while
// the next sample is processed. A finished sample that finds that result still waiting
// holds the input off until it is taken. Registers sit on an APB-style port, 4 bytes
// apart, and should only be written while the block is idle.
module ir_pulse_presence_classifier
    import irpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // sample channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        sample,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         presence_class,
    output logic               pulse_seen,
    output logic [15:0]        pulse_count,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // Configuration
    logic [DATA_W-1:0] lowpass_coef_reg, highpass_coef_reg, warmup_ticks_reg;
    logic [DATA_W-1:0] pulse_timeout_reg, short_threshold_reg, long_threshold_reg;

    // Filter and detector state
    state_t            state_reg;
    logic [DATA_W-1:0] warmup_count_reg;
    logic [DATA_W-1:0] hp_last_in_reg, hp_last_out_reg, lp_value_reg, detect_last_reg;
    logic              falling_dir_reg;
    logic [DATA_W-1:0] ticks_since_pulse_reg, count_of_pulses_reg;
    logic [1:0]        class_reg;
    logic              pulse_reg;

    // Per-sample working registers
    logic [DATA_W-1:0] x_reg;
    logic              neg_reg;

    // Output register
    logic              out_valid_reg;
    logic [1:0]        out_class_reg;
    logic              out_pulse_reg;
    logic [DATA_W-1:0] out_count_reg;

    logic in_accept, out_take, out_free, cfg_wr;
    logic warming;

    mul_req_t                    mul_req;
    logic                        mul_done;
    logic signed [PROD_HI_W-1:0] mul_hi;

    // High-pass pre-term: t = hp_out + x - hp_in, 18-bit signed, and |t|
    logic signed [MCAND_W-1:0] hp_t, hp_mag;
    // High-pass output and low-pass difference
    logic [DATA_W-1:0]         hp_y;
    logic signed [MCAND_W-1:0] lp_d;
    logic [DATA_W-1:0]         lp_f;

    // Detection / timing
    logic signed [MCAND_W-1:0] s_ext, p_ext;
    logic                      fall, rise, pulse;
    logic [DATA_W-1:0]         tsp_inc, count_new;
    logic [1:0]                class_new;

    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign warming   = (warmup_count_reg < warmup_ticks_reg);

    assign out_valid      = out_valid_reg;
    assign presence_class = out_class_reg;
    assign pulse_seen     = out_pulse_reg;
    assign pulse_count    = out_count_reg;

    // Arithmetic around the multiplier
    always_comb
    begin
        hp_t = MCAND_W'($signed(hp_last_out_reg)) + $signed({2'b00, sample})
             - MCAND_W'($signed(hp_last_in_reg));
        hp_mag = hp_t[MCAND_W-1] ? -hp_t : hp_t;
        // truncation toward zero: negate the magnitude quotient
        hp_y = neg_reg ? (16'd0 - mul_hi[DATA_W-1:0]) : mul_hi[DATA_W-1:0];
        lp_d = $signed({2'b00, hp_y}) - $signed({2'b00, lp_value_reg});
        // f = lp + floor(a * (x - lp) / 2^16)
        lp_f = lp_value_reg + mul_hi[DATA_W-1:0];
    end

    always_comb
    begin
        mul_req = '0;
        if (state_reg == ST_IDLE)
        begin
            mul_req.start  = in_accept && !warming;
            mul_req.mcand  = hp_mag;
            mul_req.mplier = highpass_coef_reg;
        end
        else if (state_reg == ST_HP)
        begin
            mul_req.start  = mul_done;
            mul_req.mcand  = lp_d;
            mul_req.mplier = lowpass_coef_reg;
        end
    end

    irpc_smul u_smul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .done    (mul_done),
        .prod_hi (mul_hi)
    );

    // Reversal detect with hysteresis, gap timer and saturating count.
    always_comb
    begin
        s_ext = MCAND_W'($signed(lp_value_reg));
        p_ext = $signed({2'b00, detect_last_reg});
        fall  = p_ext > (s_ext + $signed(HYSTERESIS));
        rise  = (p_ext + $signed(HYSTERESIS)) < s_ext;
        pulse = (fall && !falling_dir_reg) || (!fall && rise && falling_dir_reg);

        tsp_inc = (ticks_since_pulse_reg == 16'hFFFF) ? ticks_since_pulse_reg
                                                      : ticks_since_pulse_reg + 16'd1;
        count_new = count_of_pulses_reg;
        if (tsp_inc > pulse_timeout_reg)
        begin
            count_new = '0;
        end
        else if (pulse && (count_of_pulses_reg != 16'hFFFF))
        begin
            count_new = count_of_pulses_reg + 16'd1;
        end

        if (count_new < short_threshold_reg)
        begin
            class_new = CLASS_HIDDEN;
        end
        else if (count_new < long_threshold_reg)
        begin
            class_new = CLASS_SHORT;
        end
        else
        begin
            class_new = CLASS_LONG;
        end
    end

    // Sequencer and algorithm state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= ST_IDLE;
            warmup_count_reg      <= '0;
            hp_last_in_reg        <= '0;
            hp_last_out_reg       <= '0;
            lp_value_reg          <= '0;
            detect_last_reg       <= '0;
            falling_dir_reg       <= 1'b0;
            ticks_since_pulse_reg <= '0;
            count_of_pulses_reg   <= '0;
            class_reg             <= CLASS_HIDDEN;
            pulse_reg             <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (warming)
                        begin
                            warmup_count_reg      <= warmup_count_reg + 16'd1;
                            ticks_since_pulse_reg <= '0;
                            pulse_reg             <= 1'b0;
                            state_reg             <= ST_FIN;
                        end
                        else
                        begin
                            state_reg <= ST_HP;
                        end
                    end
                end
                ST_HP:
                begin
                    if (mul_done)
                    begin
                        hp_last_out_reg <= hp_y;
                        hp_last_in_reg  <= x_reg;
                        state_reg       <= ST_LP;
                    end
                end
                ST_LP:
                begin
                    if (mul_done)
                    begin
                        lp_value_reg <= lp_f;
                        state_reg    <= ST_DET;
                    end
                end
                ST_DET:
                begin
                    if (pulse)
                    begin
                        falling_dir_reg <= !falling_dir_reg;
                    end
                    detect_last_reg       <= lp_value_reg;
                    ticks_since_pulse_reg <= pulse ? 16'd0 : tsp_inc;
                    count_of_pulses_reg   <= count_new;
                    class_reg             <= class_new;
                    pulse_reg             <= pulse;
                    state_reg             <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Sample and sign of t held for the filter pass
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            x_reg   <= sample;
            neg_reg <= hp_t[MCAND_W-1];
        end
    end

    // Output register: loaded at the end of a sample, cleared when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_FIN) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FIN) && out_free)
        begin
            out_class_reg <= class_reg;
            out_pulse_reg <= pulse_reg;
            out_count_reg <= count_of_pulses_reg;
        end
    end

    // Register port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowpass_coef_reg    <= RST_LOWPASS_COEF;
            highpass_coef_reg   <= RST_HIGHPASS_COEF;
            warmup_ticks_reg    <= RST_WARMUP_TICKS;
            pulse_timeout_reg   <= RST_PULSE_TIMEOUT;
            short_threshold_reg <= RST_SHORT_THRESHOLD;
            long_threshold_reg  <= RST_LONG_THRESHOLD;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_LOWPASS_COEF:    lowpass_coef_reg    <= pwdata[DATA_W-1:0];
                REG_HIGHPASS_COEF:   highpass_coef_reg   <= pwdata[DATA_W-1:0];
                REG_WARMUP_TICKS:    warmup_ticks_reg    <= pwdata[DATA_W-1:0];
                REG_PULSE_TIMEOUT:   pulse_timeout_reg   <= pwdata[DATA_W-1:0];
                REG_SHORT_THRESHOLD: short_threshold_reg <= pwdata[DATA_W-1:0];
                REG_LONG_THRESHOLD:  long_threshold_reg  <= pwdata[DATA_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_LOWPASS_COEF:    prdata = {16'd0, lowpass_coef_reg};
            REG_HIGHPASS_COEF:   prdata = {16'd0, highpass_coef_reg};
            REG_WARMUP_TICKS:    prdata = {16'd0, warmup_ticks_reg};
            REG_PULSE_TIMEOUT:   prdata = {16'd0, pulse_timeout_reg};
            REG_SHORT_THRESHOLD: prdata = {16'd0, short_threshold_reg};
            REG_LONG_THRESHOLD:  prdata = {16'd0, long_threshold_reg};
            default:             prdata = '0;
        endcase
    end

endmodule
